// ----- rtl/positional_array_insert_delete_core_defines.svh -----
// Assertion macros used by the controller RTL of the positional array core.
`ifndef POSITIONAL_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH
`define POSITIONAL_ARRAY_INSERT_DELETE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled during reset.
`define PAID_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled during reset.
`define PAID_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/paid_pkg.sv -----
package paid_pkg;

	localparam int unsigned PAID_CAPACITY = 32;
	localparam int unsigned PAID_DATA_W = 32;
	localparam int unsigned PAID_IDX_W = 6;
	localparam int unsigned PAID_CNT_OUT_W = 6;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_DELETE = 2'd1,
		CMD_DISPLAY = 2'd2
	} paid_cmd_t;

	typedef enum logic [2:0] {
		STAT_OK = 3'd0,
		STAT_INVALID = 3'd1,
		STAT_RANGE = 3'd2,
		STAT_EMPTY = 3'd3,
		STAT_FULL = 3'd4
	} paid_status_t;

	typedef enum logic [1:0] {
		OP_HOLD,
		OP_INSERT,
		OP_DELETE,
		OP_ROTATE
	} paid_op_t;

	// Broadcast to every cell: the operation and the cell index it pivots on.
	typedef struct packed {
		paid_op_t op;
		logic [PAID_IDX_W-1:0] idx;
	} paid_ctl_t;

endpackage

// ----- rtl/paid_cell.sv -----
module paid_cell #(
	parameter int unsigned INDEX = 0
) (
	input  logic clk,
	input  paid_pkg::paid_ctl_t ctl,
	input  logic signed [paid_pkg::PAID_DATA_W-1:0] value,
	input  logic signed [paid_pkg::PAID_DATA_W-1:0] lower,
	input  logic signed [paid_pkg::PAID_DATA_W-1:0] upper,
	input  logic signed [paid_pkg::PAID_DATA_W-1:0] head,
	output logic signed [paid_pkg::PAID_DATA_W-1:0] data
);
	import paid_pkg::*;

	localparam logic [PAID_IDX_W-1:0] MY_IDX = PAID_IDX_W'(INDEX);

	logic signed [PAID_DATA_W-1:0] data_q;
	logic signed [PAID_DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		unique case (ctl.op)
			OP_INSERT: begin
				if (MY_IDX == ctl.idx) begin
					data_d = value;
				end else if (MY_IDX > ctl.idx) begin
					data_d = lower;
				end
			end
			OP_DELETE: begin
				if (MY_IDX >= ctl.idx) begin
					data_d = upper;
				end
			end
			OP_ROTATE: begin
				if (MY_IDX < ctl.idx) begin
					data_d = upper;
				end else if (MY_IDX == ctl.idx) begin
					data_d = head;
				end
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

// ----- rtl/paid_ctrl.sv -----
`include "positional_array_insert_delete_core_defines.svh"

module paid_ctrl #(
	parameter int unsigned CAPACITY = paid_pkg::PAID_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic [1:0] cmd,
	input  logic [6:0] position,
	input  logic signed [paid_pkg::PAID_DATA_W-1:0] head,
	output logic busy,
	output paid_pkg::paid_ctl_t ctl,
	output logic strobe,
	output logic [2:0] status,
	output logic signed [paid_pkg::PAID_DATA_W-1:0] element,
	output logic [paid_pkg::PAID_CNT_OUT_W-1:0] count,
	output logic last
);
	import paid_pkg::*;

	localparam int unsigned CW = $clog2(CAPACITY + 1);
	localparam int unsigned IW = $clog2(CAPACITY);

	typedef enum logic {
		S_IDLE,
		S_DISP
	} state_t;

	state_t state_q;
	logic [CW-1:0] count_q;
	logic [IW-1:0] disp_idx_q;
	logic strobe_q;
	paid_status_t status_q;
	logic signed [PAID_DATA_W-1:0] element_q;
	logic [PAID_CNT_OUT_W-1:0] count_out_q;
	logic last_q;

	paid_status_t ins_stat;
	paid_status_t del_stat;
	logic [7:0] pos_ext;
	logic [7:0] cnt_ext;
	logic [IW-1:0] top_idx;
	logic [PAID_IDX_W-1:0] rot_idx;
	logic [PAID_IDX_W-1:0] pos_idx;

	assign pos_ext = {1'b0, position};
	assign cnt_ext = 8'(count_q);
	assign top_idx = IW'(count_q - CW'(1));
	assign rot_idx = PAID_IDX_W'(count_q - CW'(1));
	assign pos_idx = PAID_IDX_W'(position - 7'd1);

	always_comb begin
		priority if (position == 7'd0) begin
			ins_stat = STAT_INVALID;
		end else if (pos_ext > cnt_ext + 8'd1) begin
			ins_stat = STAT_RANGE;
		end else if (count_q >= CW'(CAPACITY)) begin
			ins_stat = STAT_FULL;
		end else begin
			ins_stat = STAT_OK;
		end
		priority if (count_q == '0) begin
			del_stat = STAT_EMPTY;
		end else if (position == 7'd0) begin
			del_stat = STAT_INVALID;
		end else if (pos_ext > cnt_ext) begin
			del_stat = STAT_RANGE;
		end else begin
			del_stat = STAT_OK;
		end
	end

	always_comb begin
		ctl.op = OP_HOLD;
		ctl.idx = pos_idx;
		if (state_q == S_DISP) begin
			ctl.op = OP_ROTATE;
			ctl.idx = rot_idx;
		end else if (start) begin
			unique case (paid_cmd_t'(cmd))
				CMD_INSERT: begin
					if (ins_stat == STAT_OK) begin
						ctl.op = OP_INSERT;
					end
				end
				CMD_DELETE: begin
					if (del_stat == STAT_OK) begin
						ctl.op = OP_DELETE;
					end
				end
				default: begin
					ctl.op = OP_HOLD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			disp_idx_q <= '0;
			strobe_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					strobe_q <= start;
					element_q <= '0;
					last_q <= 1'b1;
					status_q <= STAT_OK;
					count_out_q <= PAID_CNT_OUT_W'(count_q);
					if (start) begin
						unique case (paid_cmd_t'(cmd))
							CMD_INSERT: begin
								status_q <= ins_stat;
								if (ins_stat == STAT_OK) begin
									count_q <= count_q + CW'(1);
									count_out_q <= PAID_CNT_OUT_W'(count_q + CW'(1));
								end
							end
							CMD_DELETE: begin
								status_q <= del_stat;
								if (del_stat == STAT_OK) begin
									count_q <= count_q - CW'(1);
									count_out_q <= PAID_CNT_OUT_W'(count_q - CW'(1));
								end
							end
							CMD_DISPLAY: begin
								if (count_q == '0) begin
									status_q <= STAT_EMPTY;
								end else begin
									strobe_q <= 1'b0;
									disp_idx_q <= '0;
									state_q <= S_DISP;
								end
							end
							default: begin
								status_q <= STAT_OK;
							end
						endcase
					end
				end
				S_DISP: begin
					strobe_q <= 1'b1;
					status_q <= STAT_OK;
					element_q <= head;
					count_out_q <= PAID_CNT_OUT_W'(count_q);
					last_q <= (disp_idx_q == top_idx);
					disp_idx_q <= disp_idx_q + IW'(1);
					if (disp_idx_q == top_idx) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q == S_DISP);
	assign strobe = strobe_q;
	assign status = status_q;
	assign element = element_q;
	assign count = count_out_q;
	assign last = last_q;

	`PAID_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CW'(CAPACITY))
	`PAID_ASSERT_NXT(a_accept_answered, start && !busy && cmd != CMD_DISPLAY, strobe && last)
	`PAID_ASSERT_IMP(a_last_frees, strobe && last, !busy)
	`PAID_ASSERT_IMP(a_stream_busy, strobe && !last, busy)
	`PAID_ASSERT_IMP(a_error_no_elem, strobe && status != STAT_OK, element == '0)

endmodule

// ----- rtl/positional_array_insert_delete_core.sv -----
// Positional array core: an ordered list of up to CAPACITY signed 32-bit entries.
// A command is transferred on the rising edge where start is high and busy is low;
// cmd selects insert at position, delete at position or display, position is 1-based.
// Every result is shown for one cycle with strobe high and carries status, element,
// count and last; the receiver cannot stall, so results are never held back.
// Insert, delete and unknown commands give one result in the cycle after the transfer
// and keep busy low, so a new command can be transferred every cycle.
// Insert and delete shift the entries through the row of cells on the edge that transfers the command.
// Display rotates the row once per cycle and streams one entry per cycle from the
// head cell: the transfer enters the display state, which then registers the head entry
// into the result; busy stays high until the last entry has been registered.
// Display on an empty list gives one result with status empty.
// Reset clears the entry count and the control state; entry contents are not cleared.
module positional_array_insert_delete_core #(
	parameter int unsigned CAPACITY = paid_pkg::PAID_CAPACITY
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic [1:0] cmd,
	input  logic [6:0] position,
	input  logic signed [paid_pkg::PAID_DATA_W-1:0] value,
	output logic strobe,
	output logic [2:0] status,
	output logic signed [paid_pkg::PAID_DATA_W-1:0] element,
	output logic [paid_pkg::PAID_CNT_OUT_W-1:0] count,
	output logic last
);
	import paid_pkg::*;

	paid_ctl_t ctl;
	logic signed [PAID_DATA_W-1:0] cell_data [CAPACITY];

	paid_ctrl #(
		.CAPACITY(CAPACITY)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.cmd(cmd),
		.position(position),
		.head(cell_data[0]),
		.busy(busy),
		.ctl(ctl),
		.strobe(strobe),
		.status(status),
		.element(element),
		.count(count),
		.last(last)
	);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [PAID_DATA_W-1:0] lower;
		logic signed [PAID_DATA_W-1:0] upper;

		if (i == 0) begin : g_first
			assign lower = cell_data[i];
		end else begin : g_mid_lo
			assign lower = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_final
			assign upper = cell_data[i];
		end else begin : g_mid_hi
			assign upper = cell_data[i+1];
		end

		paid_cell #(
			.INDEX(i)
		) u_cell (
			.clk(clk),
			.ctl(ctl),
			.value(value),
			.lower(lower),
			.upper(upper),
			.head(cell_data[0]),
			.data(cell_data[i])
		);
	end

endmodule

// ----- bench/tb_positional_array_insert_delete_core.sv -----
`default_nettype none

module tb_positional_array_insert_delete_core;
	timeunit 1ns;
	timeprecision 1ps;

	import paid_pkg::*;

	localparam int unsigned CAP = PAID_CAPACITY;
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	typedef struct {
		paid_status_t status;
		logic signed [PAID_DATA_W-1:0] element;
		logic [PAID_CNT_OUT_W-1:0] count;
		logic last;
	} array_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic [1:0] cmd = CMD_INSERT;
	logic [6:0] position = 7'd0;
	logic signed [PAID_DATA_W-1:0] value = '0;
	logic busy;
	logic strobe;
	logic [2:0] status;
	logic signed [PAID_DATA_W-1:0] element;
	logic [PAID_CNT_OUT_W-1:0] count;
	logic last;

	logic signed [PAID_DATA_W-1:0] shadow_entries [CAP];
	int unsigned shadow_count = 0;
	array_result_t pending_results [$];
	int unsigned error_count = 0;
	bit idle_en = 1'b0;

	positional_array_insert_delete_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.position(position),
		.value(value),
		.strobe(strobe),
		.status(status),
		.element(element),
		.count(count),
		.last(last)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("%0t: timeout", $realtime);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic void push_result(paid_status_t st, logic signed [PAID_DATA_W-1:0] el,
			logic lst);
		array_result_t r;
		r.status = st;
		r.element = el;
		r.count = shadow_count[PAID_CNT_OUT_W-1:0];
		r.last = lst;
		pending_results.push_back(r);
	endfunction

	function automatic void predict_array_op(logic [1:0] c, logic [6:0] p,
			logic signed [PAID_DATA_W-1:0] v);
		int unsigned pos;
		paid_status_t st;
		pos = p;
		st = STAT_OK;
		case (c)
			CMD_INSERT: begin
				if (pos == 0) st = STAT_INVALID;
				else if (pos > shadow_count + 1) st = STAT_RANGE;
				else if (shadow_count >= CAP) st = STAT_FULL;
				else begin
					for (int i = shadow_count; i >= pos; i--)
						shadow_entries[i] = shadow_entries[i-1];
					shadow_entries[pos-1] = v;
					shadow_count++;
				end
				push_result(st, '0, 1'b1);
			end
			CMD_DELETE: begin
				if (shadow_count == 0) st = STAT_EMPTY;
				else if (pos == 0) st = STAT_INVALID;
				else if (pos > shadow_count) st = STAT_RANGE;
				else begin
					for (int i = pos - 1; i + 1 < shadow_count; i++)
						shadow_entries[i] = shadow_entries[i+1];
					shadow_count--;
				end
				push_result(st, '0, 1'b1);
			end
			CMD_DISPLAY: begin
				if (shadow_count == 0) push_result(STAT_EMPTY, '0, 1'b1);
				else
					for (int i = 0; i < shadow_count; i++)
						push_result(STAT_OK, shadow_entries[i], i + 1 == shadow_count);
			end
			default: push_result(STAT_OK, '0, 1'b1);
		endcase
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (!idle_en || r < 50) return 0;
		if (r < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	function automatic logic signed [PAID_DATA_W-1:0] pick_value();
		case ($urandom_range(7))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2: return -32'sd1;
			3: return '0;
			default: return $urandom;
		endcase
	endfunction

	task automatic send_item(input logic [1:0] c, input logic [6:0] p,
			input logic signed [PAID_DATA_W-1:0] v);
		int gap;
		start <= 1'b1;
		cmd <= c;
		position <= p;
		value <= v;
		do @(posedge clk); while (busy);
		predict_array_op(c, p, v);
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic send_random(int ins_pct, int del_pct);
		int r;
		int unsigned hi;
		r = $urandom_range(99);
		hi = (shadow_count == 0) ? 1 : shadow_count;
		if (r < ins_pct)
			send_item(CMD_INSERT, 7'($urandom_range(1, shadow_count + 1)), pick_value());
		else if (r < ins_pct + del_pct)
			send_item(CMD_DELETE, 7'($urandom_range(1, hi)), pick_value());
		else if (r < ins_pct + del_pct + 6)
			send_item(CMD_DISPLAY, 7'($urandom_range(0, 127)), pick_value());
		else
			send_item(2'($urandom_range(0, 3)), 7'($urandom_range(0, 127)), $urandom);
	endtask

	task automatic test_empty_array();
		send_item(CMD_DISPLAY, 7'd0, '0);
		send_item(CMD_DELETE, 7'd1, '0);
		send_item(CMD_DELETE, 7'd0, '0);
		send_item(CMD_INSERT, 7'd0, 32'sd5);
		send_item(CMD_INSERT, 7'd2, 32'sd5);
		send_item(CMD_UNUSED, 7'd1, 32'sd5);
	endtask

	task automatic test_position_edges();
		send_item(CMD_INSERT, 7'd1, 32'sh7fff_ffff);
		send_item(CMD_INSERT, 7'd1, 32'sh8000_0000);
		send_item(CMD_INSERT, 7'd3, -32'sd1);
		send_item(CMD_INSERT, 7'd2, '0);
		send_item(CMD_INSERT, 7'd6, 32'sd9);
		send_item(CMD_INSERT, 7'd127, 32'sd9);
		send_item(CMD_DISPLAY, 7'd0, '0);
		send_item(CMD_DELETE, 7'd0, '0);
		send_item(CMD_DELETE, 7'd5, '0);
		send_item(CMD_DELETE, 7'd127, '0);
		send_item(CMD_DELETE, 7'd2, '0);
		send_item(CMD_DELETE, 7'd3, '0);
		send_item(CMD_DELETE, 7'd1, '0);
		send_item(CMD_DISPLAY, 7'd0, '0);
		send_item(CMD_UNUSED, 7'd127, -32'sd1);
	endtask

	// Mostly inserts, so the array fills up and the full case is hit repeatedly.
	task automatic test_growth();
		idle_en = 1'b0;
		repeat (30) send_random(85, 5);
		idle_en = 1'b1;
		repeat (40) send_random(80, 8);
	endtask

	task automatic test_drain_pause();
		wait_drained();
		send_item(CMD_DISPLAY, 7'd0, '0);
		wait_drained();
	endtask

	task automatic test_shrink();
		repeat (50) send_random(10, 78);
	endtask

	task automatic test_mixed_traffic();
		repeat (30) send_random(45, 40);
		idle_en = 1'b0;
		repeat (30) send_random(45, 40);
	endtask

	always @(posedge clk) begin : result_check
		array_result_t want;
		if (arst_n && strobe) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result status %0d element %0d count %0d last %0b",
					$realtime, status, element, count, last);
				error_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$realtime, want.status, status);
					error_count++;
				end
				if (element !== want.element) begin
					$display("%0t: element expected %0d actual %0d",
						$realtime, want.element, element);
					error_count++;
				end
				if (count !== want.count) begin
					$display("%0t: count expected %0d actual %0d",
						$realtime, want.count, count);
					error_count++;
				end
				if (last !== want.last) begin
					$display("%0t: last expected %0b actual %0b",
						$realtime, want.last, last);
					error_count++;
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_array();
		idle_en = 1'b1;
		test_position_edges();
		test_growth();
		test_drain_pause();
		test_shrink();
		test_mixed_traffic();
		wait_drained();
		repeat (40) @(posedge clk);
		if (error_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/paid_pkg.sv
rtl/paid_cell.sv
rtl/paid_ctrl.sv
rtl/positional_array_insert_delete_core.sv
bench/tb_positional_array_insert_delete_core.sv
